// ===== rtl/zws_pkg.sv =====
// Shared types and constants for the zone watering sequencer.
// Self-contained; imported by zone_watering_sequencer_core.
`timescale 1ns / 1ps

package zws_pkg;

    localparam int TIME_W  = 40;
    localparam int SOD_W   = 17;
    localparam int DAY_W   = 3;
    localparam int DUR_W   = 16;
    localparam int CNT_W   = 3;
    localparam int MASK_W  = 4;
    localparam int NUM_DUR = 4;
    // run-relative offsets: three full slots plus gaps plus one duration
    localparam int OFF_W   = 18;
    localparam int CFG_W   = 17;
    localparam int IDX_W   = 3;

    localparam logic [TIME_W:0] RECYCLE_DELAY = (TIME_W + 1)'(120);
    localparam logic [SOD_W:0]  PRESTART      = (SOD_W + 1)'(120);

    localparam logic [IDX_W-1:0] CFG_START_DAY    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_START_SECOND = 3'd1;
    localparam logic [IDX_W-1:0] CFG_ZONE_COUNT   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_ZONE0_DUR    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_ZONE1_DUR    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_ZONE2_DUR    = 3'd5;
    localparam logic [IDX_W-1:0] CFG_ZONE3_DUR    = 3'd6;

    typedef enum logic [2:0] {
        PH_FREE  = 3'd0,
        PH_READY = 3'd1,
        PH_RUN   = 3'd2,
        PH_DONE  = 3'd3
    } phase_t;

endpackage

// ===== rtl/zone_watering_sequencer_core.sv =====
// Zone watering sequencer: weekly / manual run, back-to-back zone slots.
// Depends on zws_pkg for widths, register indexes and the slot phase type.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall) carries one tick item per second:
//   absolute time, second of day, weekday and a manual start request.
//   Output channel (out_valid / out_stall) returns one result item per tick:
//   zone on mask, started / completed masks, occupied slot count, drop flag.
//   Config port: cfg_write with cfg_index / cfg_data writes one register per
//   cycle; write only while no tick is in flight. Run-relative slot offsets
//   are registered from the duration registers in the cycle after a write.
//   Path: an accepted item is held in the input register, and its result
//   is loaded into the result register. Throughput: one item per cycle
//   while out_stall is low. The whole tick, the slot layout adds on the
//   registered offsets and the per-slot time compares, is one pass
//   between the input register and the result register; slot state updates
//   on the same edge the result register loads, so the next item sees it.
//   Stall: while a result waits under out_stall, one more item is held in
//   the input register; in_stall rises only when both are full.
//   Reset: all slots free, no run pending, all zones off, config registers
//   at zero, both channels empty.
module zone_watering_sequencer_core
    import zws_pkg::*;
#(
    parameter int ZONES = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [TIME_W-1:0]    now_seconds,
    input  logic [SOD_W-1:0]     second_of_day,
    input  logic [DAY_W-1:0]     weekday,
    input  logic                 manual_start,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [MASK_W-1:0]    zone_on_mask,
    output logic [MASK_W-1:0]    started_mask,
    output logic [MASK_W-1:0]    completed_mask,
    output logic [CNT_W-1:0]     active_count,
    output logic                 request_dropped
);

    // only the first four slots can ever be laid out
    localparam int SLOTS = (ZONES < NUM_DUR) ? ZONES : NUM_DUR;

    // configuration
    logic [DAY_W-1:0]  start_day_reg;
    logic [SOD_W-1:0]  start_second_reg;
    logic [CNT_W-1:0]  zone_count_reg;
    logic [DUR_W-1:0]  dur_reg [NUM_DUR];

    // input register
    logic              s1_valid_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic [TIME_W-1:0] s1_sched_reg;
    logic [SOD_W-1:0]  s1_sod_reg;
    logic [DAY_W-1:0]  s1_dow_reg;
    logic              s1_manual_reg;

    // slot state
    phase_t            phase_reg  [SLOTS];
    phase_t            phase_next [SLOTS];
    logic [TIME_W-1:0] start_reg  [SLOTS];
    logic [TIME_W-1:0] start_next [SLOTS];
    logic [TIME_W-1:0] end_reg    [SLOTS];
    logic [TIME_W-1:0] end_next   [SLOTS];
    logic              pending_reg;
    logic              pending_next;
    logic [MASK_W-1:0] zone_on_reg;
    logic [MASK_W-1:0] zone_on_next;

    // result register
    logic              out_valid_reg;
    logic [MASK_W-1:0] started_reg;
    logic [MASK_W-1:0] completed_reg;
    logic [CNT_W-1:0]  active_reg;
    logic              dropped_reg;

    logic [OFF_W-1:0]  off_start_next [NUM_DUR];
    logic [OFF_W-1:0]  off_end_next   [NUM_DUR];
    logic [OFF_W-1:0]  off_start_reg  [NUM_DUR];
    logic [OFF_W-1:0]  off_end_reg    [NUM_DUR];
    logic [CNT_W-1:0]  usable;
    logic [TIME_W-1:0] sched_time;
    logic              out_free;
    logic              fire;
    logic              in_accept;
    logic [MASK_W-1:0] started;
    logic [MASK_W-1:0] completed;
    logic [CNT_W-1:0]  active;
    logic              dropped;

    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // scheduled run start on the current day, modulo 2^40
    assign sched_time = now_seconds - TIME_W'(second_of_day) + TIME_W'(start_second_reg);

    assign usable = (zone_count_reg > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : zone_count_reg;

    // run-relative slot offsets; depend on configuration only, so registered
    always_comb
    begin
        off_start_next[0] = '0;
        for (int k = 0; k < NUM_DUR; k++)
        begin
            off_end_next[k] = off_start_next[k] + OFF_W'(dur_reg[k]);
            if (k < NUM_DUR - 1)
            begin
                off_start_next[k + 1] = off_end_next[k] + OFF_W'(1);
            end
        end
    end

    always_comb
    begin
        logic              busy;
        logic              req;
        logic [TIME_W-1:0] req_time;
        phase_t            ph;

        phase_next   = phase_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        pending_next = pending_reg;
        zone_on_next = zone_on_reg;
        started      = '0;
        completed    = '0;
        dropped      = 1'b0;
        active       = '0;
        req          = 1'b0;
        req_time     = s1_now_reg;
        busy         = 1'b0;

        for (int i = 0; i < SLOTS; i++)
        begin
            busy = busy | (phase_reg[i] != PH_FREE);
        end

        if (s1_manual_reg)
        begin
            req = 1'b1;
        end
        else if (s1_dow_reg == start_day_reg)
        begin
            if ((start_second_reg <= ({1'b0, s1_sod_reg} + PRESTART)) &&
                (start_second_reg >= s1_sod_reg) && !pending_reg)
            begin
                req          = 1'b1;
                req_time     = s1_sched_reg;
                pending_next = 1'b1;
            end
            if (start_second_reg <= s1_sod_reg)
            begin
                pending_next = 1'b0;
            end
        end

        if (req)
        begin
            if (busy)
            begin
                dropped = 1'b1;
            end
            else
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (CNT_W'(i) < usable)
                    begin
                        start_next[i] = req_time + TIME_W'(off_start_reg[i]);
                        end_next[i]   = req_time + TIME_W'(off_end_reg[i]);
                        phase_next[i] = PH_READY;
                    end
                end
            end
        end

        // a slot advances at most one phase here; a slot laid out on this tick may also start on it
        for (int i = 0; i < SLOTS; i++)
        begin
            ph = phase_next[i];
            case (ph)
                PH_DONE:
                begin
                    // recycle compare does not wrap
                    if (({1'b0, end_next[i]} + RECYCLE_DELAY) <= {1'b0, s1_now_reg})
                    begin
                        ph = PH_FREE;
                    end
                end
                PH_RUN:
                begin
                    if (end_next[i] <= s1_now_reg)
                    begin
                        ph              = PH_DONE;
                        zone_on_next[i] = 1'b0;
                        completed[i]    = 1'b1;
                    end
                end
                PH_READY:
                begin
                    if (start_next[i] <= s1_now_reg)
                    begin
                        ph              = PH_RUN;
                        zone_on_next[i] = 1'b1;
                        started[i]      = 1'b1;
                    end
                end
                default:
                begin
                    ph = phase_next[i];
                end
            endcase
            phase_next[i] = ph;
            if (ph != PH_FREE)
            begin
                active = active + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_day_reg    <= '0;
            start_second_reg <= '0;
            zone_count_reg   <= '0;
            for (int k = 0; k < NUM_DUR; k++)
            begin
                dur_reg[k] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_START_DAY:    start_day_reg    <= cfg_data[DAY_W-1:0];
                CFG_START_SECOND: start_second_reg <= cfg_data[SOD_W-1:0];
                CFG_ZONE_COUNT:   zone_count_reg   <= cfg_data[CNT_W-1:0];
                CFG_ZONE0_DUR:    dur_reg[0]       <= cfg_data[DUR_W-1:0];
                CFG_ZONE1_DUR:    dur_reg[1]       <= cfg_data[DUR_W-1:0];
                CFG_ZONE2_DUR:    dur_reg[2]       <= cfg_data[DUR_W-1:0];
                CFG_ZONE3_DUR:    dur_reg[3]       <= cfg_data[DUR_W-1:0];
                default:          ;
            endcase
        end
    end

    // offsets are registered from the duration registers and update in the cycle
    // after a write; an item that reaches the slot logic before then uses the old layout
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_DUR; k++)
            begin
                off_start_reg[k] <= '0;
                off_end_reg[k]   <= '0;
            end
        end
        else
        begin
            off_start_reg <= off_start_next;
            off_end_reg   <= off_end_next;
        end
    end

    // channel control and slot control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
            zone_on_reg   <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                phase_reg[i] <= PH_FREE;
            end
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
                pending_reg   <= pending_next;
                zone_on_reg   <= zone_on_next;
                phase_reg     <= phase_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_now_reg    <= now_seconds;
            s1_sched_reg  <= sched_time;
            s1_sod_reg    <= second_of_day;
            s1_dow_reg    <= weekday;
            s1_manual_reg <= manual_start;
        end
        if (fire)
        begin
            start_reg     <= start_next;
            end_reg       <= end_next;
            started_reg   <= started;
            completed_reg <= completed;
            active_reg    <= active;
            dropped_reg   <= dropped;
        end
    end

    assign out_valid       = out_valid_reg;
    assign zone_on_mask    = zone_on_reg;
    assign started_mask    = started_reg;
    assign completed_mask  = completed_reg;
    assign active_count    = active_reg;
    assign request_dropped = dropped_reg;

    // a zone cannot start and complete on the same tick, and is off once complete
    a_mask_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((started_mask & completed_mask) == '0) &&
                       ((zone_on_mask & completed_mask) == '0)))
        else $error("started/completed/zone_on masks overlap");

    // every watering zone holds an occupied slot
    a_on_within_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones(zone_on_mask) <= int'(active_count)))
        else $error("zone on without an occupied slot");

    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(active_count) <= SLOTS))
        else $error("active count exceeds slot count");

    // input side backs up only when the input and result registers are full and out_stall is high
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a held item");

endmodule
